// File: rtl/integer_text_formatter_top_assert.svh
// Assertion macros shared by the checker of the integer text formatter.
// Both macros expect clk to be visible where they are used; ITF_ASSERT_NEXT also arst_n.
`ifndef INTEGER_TEXT_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TEXT_FORMATTER_TOP_ASSERT_SVH

// Implication into the next cycle, switched off while reset is asserted.
`define ITF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("formatter assertion failed");

// Condition that must hold at every clock edge, reset included.
`define ITF_ASSERT_NOW(lbl, cond) \
	lbl: assert property (@(posedge clk) (cond)) \
		else $error("formatter assertion failed");

`endif

// File: rtl/itf_pkg.sv
// Package of the integer text formatter: mode codes, character constants,
// the sign code type and the descriptor passed from front end to back end.
`default_nettype none

package itf_pkg;

	// Conversion mode codes.
	localparam logic [2:0] MODE_DEC    = 3'd0;
	localparam logic [2:0] MODE_OCT    = 3'd1;
	localparam logic [2:0] MODE_HEXL   = 3'd2;
	localparam logic [2:0] MODE_HEXU   = 3'd3;
	localparam logic [2:0] MODE_BIN    = 3'd4;
	localparam logic [2:0] MODE_PTR    = 3'd5;
	localparam logic [2:0] MODE_CHAR   = 3'd6;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	// Characters.
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_X_UPPER = 8'd88;
	localparam logic [7:0] CH_X_LOWER = 8'd120;

	// Precision limit and the longest field body (sign, prefix, 33 digits).
	localparam logic [5:0] PREC_LIMIT = 6'd32;
	localparam int MAX_BODY = 36;

	// Reciprocal of ten scaled by two to the 35.
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

	typedef enum logic [1:0] {
		SGN_NONE,
		SGN_MINUS,
		SGN_PLUS,
		SGN_SPACE
	} itf_sign_t;

	// One classified field, as queued for the back end.
	typedef struct packed {
		logic [31:0] mag;
		logic [2:0]  shift;
		logic        upper;
		logic        is_char;
		itf_sign_t   sign;
		logic        prefix;
		logic        zfill;
		logic        lj;
		logic        oct_alt;
		logic [5:0]  width;
		logic [5:0]  prec;
	} itf_desc_t;

endpackage

`default_nettype wire

// File: rtl/itf_if.sv
// Channel interfaces of the integer text formatter: operand in, text out.
// Stand-alone; no package needed.
`default_nettype none

interface itf_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] value;
	logic        left_align;
	logic        force_plus;
	logic        space_sign;
	logic        zero_pad;
	logic        alternate_form;
	logic [5:0]  field_width;
	logic [5:0]  digit_precision;

	modport source (output valid, mode, value, left_align, force_plus, space_sign,
		zero_pad, alternate_form, field_width, digit_precision, input ready);
	modport sink (input valid, mode, value, left_align, force_plus, space_sign,
		zero_pad, alternate_form, field_width, digit_precision, output ready);
endinterface

interface itf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

// File: rtl/integer_text_formatter_top.sv
// Integer text formatter, top level: printf-style conversion of one 32-bit operand.
// Depends on itf_pkg, itf_if.sv, itf_front, itf_queue and itf_back.
//
// Usage:
// The operand channel takes one transaction per field: mode, value, flags, width
// and precision. The text channel returns the field as ASCII characters, one
// transaction each, with last_char set on the final one. Mode 7 is taken and
// produces nothing. A field is cut at MAX_FIELD_WIDTH characters.
// Timing: a front end classifies each operand in the cycle it is taken and
// writes it into a two-entry queue, so up to two operands are taken while the
// back end is busy. The back end works one field at a time: it loads the
// descriptor, extracts the digits (decimal through the reciprocal multiplier, a
// multiply and a divide step per digit, at most 10 digits; octal, hex, pointer
// and binary by shifting, at most 32 digits; char none), sizes the field in
// ST_LEN and then ST_BOUND, then emits one character per cycle while the
// receiver takes them; it picks up the next field only once back in idle.
// Reset clears the queue, the sequencer and the output valid. When the receiver
// stalls, the held character stays put, the back end waits and the queue fills.
`default_nettype none

module integer_text_formatter_top import itf_pkg::*; #(
	parameter int MAX_FIELD_WIDTH = 63
) (
	input  wire logic clk,
	input  wire logic arst_n,
	itf_in_if.sink    operand,
	itf_out_if.source text
);

	logic      push_valid;
	logic      push_ready;
	itf_desc_t push_desc;
	logic      pop_valid;
	logic      pop_ready;
	itf_desc_t pop_desc;

	itf_front u_front (
		.operand    (operand),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	itf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	itf_back #(
		.MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.text      (text)
	);

endmodule

`default_nettype wire

// File: rtl/itf_front.sv
// Front end of the integer text formatter: accepts operands and classifies them.
// Depends on itf_pkg and the channel interface in itf_if.sv.
`default_nettype none

module itf_front import itf_pkg::*; (
	itf_in_if.sink    operand,
	output logic      push_valid,
	input  wire logic push_ready,
	output itf_desc_t push_desc
);

	logic        is_dec;
	logic        is_hex;
	logic        is_ptr;
	logic        is_chr;
	logic        neg;
	logic [5:0]  prec_sat;
	logic        val_nz;

	// The unused mode code is taken and dropped without a descriptor.
	assign operand.ready = push_ready;
	assign push_valid    = operand.valid && (operand.mode <= MODE_CHAR);

	assign is_dec   = (operand.mode == MODE_DEC);
	assign is_hex   = (operand.mode == MODE_HEXL) || (operand.mode == MODE_HEXU);
	assign is_ptr   = (operand.mode == MODE_PTR);
	assign is_chr   = (operand.mode == MODE_CHAR);
	assign neg      = is_dec && operand.value[31];
	assign val_nz   = (operand.value != 32'd0);
	assign prec_sat = (operand.digit_precision > PREC_LIMIT) ? PREC_LIMIT
		: operand.digit_precision;

	// Build the descriptor: magnitude, radix, sign, prefix and padding style.
	always_comb begin
		push_desc = '0;
		if (is_chr) begin
			push_desc.mag = {24'd0, operand.value[7:0]};
		end else if (neg) begin
			push_desc.mag = 32'd0 - operand.value;
		end else begin
			push_desc.mag = operand.value;
		end

		unique case (operand.mode)
			MODE_OCT:  push_desc.shift = 3'd3;
			MODE_BIN:  push_desc.shift = 3'd1;
			MODE_HEXL, MODE_HEXU, MODE_PTR: push_desc.shift = 3'd4;
			default:   push_desc.shift = 3'd0;
		endcase

		push_desc.upper   = (operand.mode == MODE_HEXU);
		push_desc.is_char = is_chr;

		priority if (!is_dec) begin
			push_desc.sign = SGN_NONE;
		end else if (neg) begin
			push_desc.sign = SGN_MINUS;
		end else if (operand.force_plus) begin
			push_desc.sign = SGN_PLUS;
		end else if (operand.space_sign) begin
			push_desc.sign = SGN_SPACE;
		end else begin
			push_desc.sign = SGN_NONE;
		end

		push_desc.prefix  = is_ptr || (operand.alternate_form && is_hex && val_nz);
		push_desc.oct_alt = operand.alternate_form && (operand.mode == MODE_OCT) && val_nz;

		// A pointer ignores all flags, width and precision.
		if (is_ptr) begin
			push_desc.lj    = 1'b0;
			push_desc.zfill = 1'b0;
			push_desc.width = 6'd0;
			push_desc.prec  = 6'd0;
		end else begin
			push_desc.lj    = operand.left_align;
			push_desc.width = operand.field_width;
			push_desc.prec  = is_chr ? 6'd0 : prec_sat;
			push_desc.zfill = operand.zero_pad && !operand.left_align
				&& (is_chr || (prec_sat == 6'd0));
		end
	end

endmodule

`default_nettype wire

// File: rtl/itf_queue.sv
// Two-entry queue of field descriptors between front end and back end.
// Depends on itf_pkg for the descriptor type.
`default_nettype none

module itf_queue import itf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire itf_desc_t  push_desc,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output itf_desc_t       pop_desc
);

	itf_desc_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_desc   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

// File: rtl/itf_back.sv
// Back end of the integer text formatter: digit extraction and character output.
// Depends on itf_pkg and the channel interface in itf_if.sv.
`default_nettype none

module itf_back import itf_pkg::*; #(
	parameter int MAX_FIELD_WIDTH = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pop_valid,
	output logic            pop_ready,
	input  wire itf_desc_t  pop_desc,
	itf_out_if.source       text
);

	localparam int MAXC = (MAX_FIELD_WIDTH > MAX_BODY) ? MAX_FIELD_WIDTH : MAX_BODY;
	localparam int CW   = $clog2(MAXC + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SHIFT,
		ST_LEN,
		ST_BOUND,
		ST_EMIT
	} state_t;

	state_t      state_q;
	itf_desc_t   desc_q;
	logic [31:0] mag_q;
	logic [63:0] prod_s1;
	logic [3:0]  digs_q [32];
	logic [5:0]  nd_q;
	logic [5:0]  zeros_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] e1_q, e2_q, e3_q, e5_q, e6_q, limit_q;
	logic [CW-1:0] n_q;
	logic        ov_q;
	logic [7:0]  char_q;
	logic        last_q;

	logic [28:0] quot;
	logic [31:0] rem;
	logic [3:0]  sh_digit;
	logic [31:0] sh_next;
	logic [5:0]  zeros_c;
	logic [CW-1:0] w_ext, w_sat, pad, lpad, zpad, rpad, s_len, np_len;
	logic [CW-1:0] e1, e2, e3, e4, e5, e6, total;
	logic [CW-1:0] dig_off;
	logic [3:0]  dig_val;
	logic [7:0]  alpha;
	logic [7:0]  dig_char;
	logic [7:0]  next_char;
	logic        next_last;
	logic        slot_free;

	assign pop_ready      = (state_q == ST_IDLE);
	assign text.valid     = ov_q;
	assign text.out_char  = char_q;
	assign text.last_char = last_q;
	assign slot_free      = !ov_q || text.ready;

	// Decimal digit from the registered reciprocal product.
	assign quot = prod_s1[63:35];
	assign rem  = mag_q - ({quot, 3'b000} + {2'b00, quot, 1'b0});

	// Power-of-two radix digit.
	assign sh_digit = mag_q[3:0] & ~(4'hF << desc_q.shift);
	assign sh_next  = mag_q >> desc_q.shift;

	// Zero fill to precision, plus the octal alternate-form zero.
	always_comb begin
		zeros_c = (desc_q.prec > nd_q) ? (desc_q.prec - nd_q) : 6'd0;
		if (desc_q.oct_alt && (zeros_c == 6'd0)) begin
			zeros_c = 6'd1;
		end
	end

	// Segment boundaries of the field.
	assign s_len  = CW'(desc_q.sign != SGN_NONE);
	assign np_len = desc_q.prefix ? CW'(2) : '0;
	assign w_ext  = CW'(desc_q.width);
	assign w_sat  = (w_ext > CW'(MAX_FIELD_WIDTH)) ? CW'(MAX_FIELD_WIDTH) : w_ext;
	assign pad    = (w_sat > len_q) ? (w_sat - len_q) : '0;
	assign lpad   = (!desc_q.lj && !desc_q.zfill) ? pad : '0;
	assign zpad   = desc_q.zfill ? pad : '0;
	assign rpad   = desc_q.lj ? pad : '0;
	assign e1     = lpad;
	assign e2     = e1 + s_len;
	assign e3     = e2 + np_len;
	assign e4     = e3 + zpad;
	assign e5     = e4 + CW'(zeros_q);
	assign e6     = e5 + CW'(nd_q);
	assign total  = e6 + rpad;

	// Character at the current position; digits are stored least significant first.
	assign dig_off  = e6_q - CW'(1) - n_q;
	assign dig_val  = digs_q[dig_off[4:0]];
	assign alpha    = desc_q.upper ? CH_UPPER_A : CH_LOWER_A;
	assign dig_char = desc_q.is_char ? desc_q.mag[7:0]
		: (dig_val >= 4'd10) ? (alpha + {4'd0, dig_val} - 8'd10)
		: (CH_ZERO + {4'd0, dig_val});

	always_comb begin
		priority if (n_q < e1_q) begin
			next_char = CH_SPACE;
		end else if (n_q < e2_q) begin
			unique case (desc_q.sign)
				SGN_MINUS: next_char = CH_MINUS;
				SGN_PLUS:  next_char = CH_PLUS;
				default:   next_char = CH_SPACE;
			endcase
		end else if (n_q < e3_q) begin
			next_char = (n_q == e2_q) ? CH_ZERO : (desc_q.upper ? CH_X_UPPER : CH_X_LOWER);
		end else if (n_q < e5_q) begin
			next_char = CH_ZERO;
		end else if (n_q < e6_q) begin
			next_char = dig_char;
		end else begin
			next_char = CH_SPACE;
		end
	end
	assign next_last = ((n_q + CW'(1)) == limit_q);

	// Sequencer: take a descriptor, extract digits, size the field, emit characters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			// Outside emission a taken character simply empties the output register.
			if (ov_q && text.ready && (state_q != ST_EMIT)) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						desc_q <= pop_desc;
						mag_q  <= pop_desc.mag;
						if (pop_desc.is_char) begin
							nd_q    <= 6'd1;
							state_q <= ST_LEN;
						end else begin
							nd_q    <= 6'd0;
							state_q <= (pop_desc.shift == 3'd0) ? ST_MUL : ST_SHIFT;
						end
					end
				end
				ST_MUL: begin
					prod_s1 <= mag_q * RECIP_TEN;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					digs_q[nd_q[4:0]] <= rem[3:0];
					nd_q    <= nd_q + 6'd1;
					mag_q   <= {3'b000, quot};
					state_q <= (quot == 29'd0) ? ST_LEN : ST_MUL;
				end
				ST_SHIFT: begin
					digs_q[nd_q[4:0]] <= sh_digit;
					nd_q  <= nd_q + 6'd1;
					mag_q <= sh_next;
					if ((sh_next == 32'd0) || (nd_q == 6'd31)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					zeros_q <= zeros_c;
					len_q   <= s_len + np_len + CW'(zeros_c) + CW'(nd_q);
					state_q <= ST_BOUND;
				end
				ST_BOUND: begin
					e1_q    <= e1;
					e2_q    <= e2;
					e3_q    <= e3;
					e5_q    <= e5;
					e6_q    <= e6;
					limit_q <= (total > CW'(MAX_FIELD_WIDTH)) ? CW'(MAX_FIELD_WIDTH) : total;
					n_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						ov_q   <= 1'b1;
						char_q <= next_char;
						last_q <= next_last;
						n_q    <= n_q + CW'(1);
						if (next_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/itf_checker.sv
// Port-level checks of the integer text formatter, bound to its top level.
// Depends on the macros in integer_text_formatter_top_assert.svh.
`default_nettype none

`include "integer_text_formatter_top_assert.svh"

module itf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_last,
	input wire logic [7:0] out_char
);

	// No character is offered while reset is asserted.
	`ITF_ASSERT_NOW(a_reset_idle, arst_n || !out_valid)

	// A stalled character stays offered and unchanged, its end marker included.
	`ITF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid)
	`ITF_ASSERT_NEXT(a_stall_stable, out_valid && !out_ready, $stable(out_char))
	`ITF_ASSERT_NEXT(a_stall_last, out_valid && !out_ready, $stable(out_last))

endmodule

bind integer_text_formatter_top itf_checker u_itf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_last  (text.last_char),
	.out_char  (text.out_char)
);

`default_nettype wire

// File: tb/tb.sv
// Testbench of the integer text formatter: directed and random operands with
// idling on both channels, checked character by character against a predictor.
// Depends on itf_pkg, itf_if.sv and integer_text_formatter_top.
`default_nettype none

module tb;
	import itf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] value;
		logic        lj, fp, ss, zp, af;
		logic [5:0]  width;
		logic [5:0]  prec;
	} operand_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	// Scoreboard: expands each accepted operand into its expected characters.
	class text_scoreboard;
		text_char_t pending[$];
		int errors;
		text_char_t field[$];
		int pending_in_field;

		function void put_char(logic [7:0] c);
			text_char_t t;
			if (pending_in_field < 63) begin
				t.ch = c;
				t.last = 1'b0;
				field.push_back(t);
				pending_in_field++;
			end
		endfunction

		function void put_run(logic [7:0] c, int count);
			for (int i = 0; i < count; i++) put_char(c);
		endfunction

		function void note_operand(operand_t op);
			logic [7:0] digits[$];
			logic [31:0] mag;
			logic [7:0] sign, pre1, alpha;
			int base, np, zeros, len, pad, w, p;
			logic lj, zp, zfill;
			logic [31:0] d;
			field = {};
			pending_in_field = 0;
			if (op.mode == MODE_UNUSED) return;
			w = op.width;
			p = (op.prec > PREC_LIMIT) ? int'(PREC_LIMIT) : int'(op.prec);
			lj = op.lj;
			zp = op.zp;
			sign = 8'd0;
			np = 0;
			zeros = 0;
			pre1 = 8'd0;
			if (op.mode == MODE_CHAR) begin
				digits.push_back(op.value[7:0]);
				zfill = zp && !lj;
			end else begin
				mag = op.value;
				base = 10;
				alpha = CH_LOWER_A;
				if (op.mode == MODE_PTR) begin
					lj = 0; zp = 0; w = 0; p = 0;
					np = 2; pre1 = CH_X_LOWER;
				end
				case (op.mode)
					MODE_DEC: begin
						if (op.value[31]) begin
							mag = -op.value;
							sign = CH_MINUS;
						end else if (op.fp) sign = CH_PLUS;
						else if (op.ss) sign = CH_SPACE;
					end
					MODE_OCT: base = 8;
					MODE_BIN: base = 2;
					default: begin
						base = 16;
						if (op.mode == MODE_HEXU) alpha = CH_UPPER_A;
					end
				endcase
				do begin
					d = mag % base;
					mag = mag / base;
					digits.push_front(d >= 10 ? 8'(d - 10 + alpha) : 8'(d + CH_ZERO));
				end while (mag != 0);
				zeros = (p > digits.size()) ? p - digits.size() : 0;
				if (op.af && op.mode == MODE_OCT && zeros == 0 && digits[0] != CH_ZERO)
					zeros = 1;
				if (op.af && (op.mode == MODE_HEXL || op.mode == MODE_HEXU) && op.value != 0)
				begin
					np = 2;
					pre1 = (op.mode == MODE_HEXU) ? CH_X_UPPER : CH_X_LOWER;
				end
				zfill = zp && !lj && p == 0;
			end
			len = (sign != 0) + np + zeros + digits.size();
			pad = (w > len) ? w - len : 0;
			// Standard C placement: pad, sign, prefix, zero fill, digits, pad.
			if (!lj && !zfill) put_run(CH_SPACE, pad);
			if (sign != 0) put_char(sign);
			if (np == 2) begin
				put_char(CH_ZERO);
				put_char(pre1);
			end
			if (zfill) put_run(CH_ZERO, pad);
			put_run(CH_ZERO, zeros);
			foreach (digits[i]) put_char(digits[i]);
			if (lj) put_run(CH_SPACE, pad);
			if (field.size() > 0) field[field.size() - 1].last = 1'b1;
			foreach (field[i]) pending.push_back(field[i]);
		endfunction

		function void check_char(logic [7:0] c, logic last);
			text_char_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected character %02h last %0b", $realtime, c, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (c !== e.ch || last !== e.last) begin
				$display("%0t: mismatch: expected %02h last %0b, actual %02h last %0b",
					$realtime, e.ch, e.last, c, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	itf_in_if  operand();
	itf_out_if text();

	integer_text_formatter_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand),
		.text(text)
	);

	text_scoreboard formatted = new();
	int send_idle_pct = 24;
	int recv_idle_pct = 55;
	bit hold_off = 1'b0;

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: ready changes at the falling edge, characters are checked at the rising one.
	initial begin
		text.ready = 1'b0;
		forever begin
			@(negedge clk);
			text.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && text.valid && text.ready)
			formatted.check_char(text.out_char, text.last_char);
	end

	// Sends one operand and notes it once the transaction is taken.
	task automatic send_operand(operand_t op);
		while ($urandom_range(99) < send_idle_pct) begin
			operand.valid <= 1'b0;
			@(negedge clk);
		end
		operand.valid <= 1'b1;
		operand.mode <= op.mode;
		operand.value <= op.value;
		operand.left_align <= op.lj;
		operand.force_plus <= op.fp;
		operand.space_sign <= op.ss;
		operand.zero_pad <= op.zp;
		operand.alternate_form <= op.af;
		operand.field_width <= op.width;
		operand.digit_precision <= op.prec;
		do @(posedge clk); while (!operand.ready);
		formatted.note_operand(op);
		@(negedge clk);
	endtask

	function automatic operand_t random_operand();
		operand_t op;
		op.mode = ($urandom_range(16) == 0) ? MODE_UNUSED : 3'($urandom_range(6));
		case ($urandom_range(3))
			0: op.value = $urandom_range(20);
			1: op.value = -$urandom_range(20);
			default: op.value = $urandom;
		endcase
		{op.lj, op.fp, op.ss, op.zp, op.af} = 5'($urandom);
		op.width = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(14));
		op.prec = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12));
		return op;
	endfunction

	function automatic operand_t make_op(logic [2:0] m, logic [31:0] v, logic [4:0] flags,
		logic [5:0] w, logic [5:0] p);
		operand_t op;
		op.mode = m;
		op.value = v;
		{op.lj, op.fp, op.ss, op.zp, op.af} = flags;
		op.width = w;
		op.prec = p;
		return op;
	endfunction

	// Stimulus: directed cases, a receiver hold-off, then three random phases with different idling.
	initial begin
		operand_t op;
		arst_n <= 1'b0;
		operand.valid = 1'b0;
		operand.mode = '0;
		operand.value = '0;
		operand.left_align = 1'b0;
		operand.force_plus = 1'b0;
		operand.space_sign = 1'b0;
		operand.zero_pad = 1'b0;
		operand.alternate_form = 1'b0;
		operand.field_width = '0;
		operand.digit_precision = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Flags are ordered left_align, force_plus, space_sign, zero_pad, alternate_form.
		send_operand(make_op(MODE_DEC, 32'd0, 5'b00000, 6'd0, 6'd0));
		send_operand(make_op(MODE_DEC, 32'h8000_0000, 5'b00010, 6'd15, 6'd0));
		send_operand(make_op(MODE_DEC, 32'h7FFF_FFFF, 5'b01000, 6'd0, 6'd0));
		send_operand(make_op(MODE_DEC, 32'd42, 5'b00100, 6'd8, 6'd0));
		send_operand(make_op(MODE_DEC, 32'hFFFF_FFFF, 5'b10000, 6'd63, 6'd5));
		send_operand(make_op(MODE_OCT, 32'd8, 5'b01101, 6'd6, 6'd0));
		send_operand(make_op(MODE_OCT, 32'd0, 5'b00001, 6'd0, 6'd0));
		send_operand(make_op(MODE_OCT, 32'd7, 5'b00001, 6'd0, 6'd4));
		send_operand(make_op(MODE_HEXL, 32'hDEAD_BEEF, 5'b00011, 6'd12, 6'd0));
		send_operand(make_op(MODE_HEXU, 32'd0, 5'b00001, 6'd4, 6'd0));
		send_operand(make_op(MODE_HEXU, 32'hABC, 5'b00011, 6'd10, 6'd6));
		send_operand(make_op(MODE_BIN, 32'hFFFF_FFFF, 5'b00001, 6'd63, 6'd63));
		send_operand(make_op(MODE_BIN, 32'd5, 5'b10000, 6'd9, 6'd32));
		send_operand(make_op(MODE_PTR, 32'h1234, 5'b11111, 6'd20, 6'd10));
		send_operand(make_op(MODE_CHAR, 32'h41, 5'b00010, 6'd5, 6'd9));
		send_operand(make_op(MODE_CHAR, 32'hFF, 5'b11101, 6'd4, 6'd0));
		send_operand(make_op(MODE_UNUSED, 32'd1, 5'b11111, 6'd63, 6'd63));
		send_operand(make_op(MODE_DEC, 32'h8000_0000, 5'b01100, 6'd63, 6'd32));
		send_operand(make_op(MODE_DEC, 32'd3, 5'b01110, 6'd0, 6'd40));

		// Long receiver hold-off while operands keep coming, so the queue fills.
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (6) send_operand(random_operand());
		join

		repeat (70) send_operand(random_operand());
		send_idle_pct = 55;
		recv_idle_pct = 24;
		repeat (70) send_operand(random_operand());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (70) send_operand(random_operand());
		operand.valid <= 1'b0;

		while (formatted.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (formatted.errors == 0 && formatted.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/itf_pkg.sv
rtl/itf_if.sv
rtl/itf_front.sv
rtl/itf_queue.sv
rtl/itf_back.sv
rtl/integer_text_formatter_top.sv
rtl/itf_checker.sv
tb/tb.sv
